// ----- design/lrt_pkg.sv -----
// ----------------------------------------------------------------------------
// lrt_pkg: shared types and constants of the LRU replacement table
// Sizes of the slot store, opcode and status codes, and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package lrt_pkg;

    // Table geometry.
    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int AGE_W    = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;

    // Operation codes of a request beat.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_EVICT  = 2'd1,
        OP_ERASE  = 2'd2
    } t_opcode;

    // Status codes of a response beat.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

// ----- design/lrt_if.sv -----
// ----------------------------------------------------------------------------
// lrt_if: request and response channels of the LRU replacement table
// Valid/ready channels; a beat moves on a clock edge with both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrt_req_if;
    logic                           valid;
    logic                           ready;
    logic [lrt_pkg::OP_W-1:0]       opcode;
    logic [lrt_pkg::KEY_W-1:0]      key;

    modport source (output valid, output opcode, output key, input ready);
    modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface lrt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [lrt_pkg::STAT_W-1:0]     status;
    logic [lrt_pkg::KEY_W-1:0]      victim_key;
    logic [lrt_pkg::COUNT_W-1:0]    entry_count;

    modport source (output valid, output status, output victim_key,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input victim_key,
                    input entry_count, output ready);
endinterface

`default_nettype wire

// ----- design/lru_replacer_table_core.sv -----
// ----------------------------------------------------------------------------
// lru_replacer_table_core: least-recently-used replacement table
// Holds up to 16 distinct keys with a recency rank each; supports insert or
// refresh, evict of the least recent key, and erase of a given key.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Fields                               Beat
//  i_req     in   opcode[1:0], key[31:0]               one operation
//  o_rsp     out  status[1:0], victim_key[31:0],       one result per request
//                 entry_count[4:0]
//
//  A request passes from acceptance through the scan, which walks the 16 slots
//  through one key and one rank comparator behind the key store's registered
//  read, then the update state and the response state; the next request is
//  taken in the idle state. Reset clears the valid marks, ranks and count
//  at once; the key store needs no clearing. No request is taken until the
//  response has gone; o_rsp stalls hold it.
//
`default_nettype none

module lru_replacer_table_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    lrt_req_if.sink     i_req,
    lrt_rsp_if.source   o_rsp
);

    localparam int CAP = lrt_pkg::CAPACITY;

    // Sequencer state.
    lrt_pkg::t_state                    r_state, n_state;

    // Latched request.
    lrt_pkg::t_opcode                   r_op, n_op;
    logic [lrt_pkg::KEY_W-1:0]          r_key, n_key;

    // Slot bookkeeping.
    logic                               r_valid [CAP];
    logic                               n_valid [CAP];
    logic [lrt_pkg::AGE_W-1:0]          r_age [CAP];
    logic [lrt_pkg::AGE_W-1:0]          n_age [CAP];
    logic [lrt_pkg::COUNT_W-1:0]        r_count, n_count;

    // Key store and its read pipeline.
    logic [lrt_pkg::KEY_W-1:0]          r_key_mem [CAP];
    logic [lrt_pkg::KEY_W-1:0]          r_rd_data;
    logic                               r_rd_valid, n_rd_valid;
    logic [lrt_pkg::SLOT_W-1:0]         r_rd_idx, n_rd_idx;
    logic [lrt_pkg::COUNT_W-1:0]        r_cnt, n_cnt;
    logic                               w_mem_we;

    // Scan results.
    logic                               r_hit, n_hit;
    logic [lrt_pkg::SLOT_W-1:0]         r_hit_idx, n_hit_idx;
    logic [lrt_pkg::AGE_W-1:0]          r_hit_age, n_hit_age;
    logic                               r_free_found, n_free_found;
    logic [lrt_pkg::SLOT_W-1:0]         r_free_idx, n_free_idx;
    logic                               r_best_found, n_best_found;
    logic [lrt_pkg::SLOT_W-1:0]         r_best_idx, n_best_idx;
    logic [lrt_pkg::AGE_W-1:0]          r_best_age, n_best_age;
    logic [lrt_pkg::KEY_W-1:0]          r_best_key, n_best_key;

    // Response register.
    lrt_pkg::t_status                   r_status, n_status;
    logic [lrt_pkg::KEY_W-1:0]          r_victim, n_victim;
    logic [lrt_pkg::COUNT_W-1:0]        r_out_count, n_out_count;

    // Slot under comparison in this scan cycle.
    logic                               w_cur_valid;
    logic [lrt_pkg::AGE_W-1:0]          w_cur_age;

    assign w_cur_valid = r_valid[r_rd_idx];
    assign w_cur_age   = r_age[r_rd_idx];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lrt_pkg::S_IDLE: begin
                if (i_req.valid) n_state = lrt_pkg::S_SCAN;
            end
            lrt_pkg::S_SCAN: begin
                if (r_cnt == lrt_pkg::COUNT_W'(CAP)) n_state = lrt_pkg::S_UPDATE;
            end
            lrt_pkg::S_UPDATE: begin
                n_state = lrt_pkg::S_RESP;
            end
            lrt_pkg::S_RESP: begin
                if (o_rsp.ready) n_state = lrt_pkg::S_IDLE;
            end
            default: begin
                n_state = lrt_pkg::S_IDLE;
            end
        endcase
    end

    // Handshake and response outputs.
    always_comb begin
        i_req.ready       = (r_state == lrt_pkg::S_IDLE);
        o_rsp.valid       = (r_state == lrt_pkg::S_RESP);
        o_rsp.status      = r_status;
        o_rsp.victim_key  = r_victim;
        o_rsp.entry_count = r_out_count;
    end

    // Datapath: scan comparisons and the table update.
    always_comb begin
        n_op         = r_op;
        n_key        = r_key;
        n_valid      = r_valid;
        n_age        = r_age;
        n_count      = r_count;
        n_rd_valid   = r_rd_valid;
        n_rd_idx     = r_rd_idx;
        n_cnt        = r_cnt;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_hit_age    = r_hit_age;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_best_found = r_best_found;
        n_best_idx   = r_best_idx;
        n_best_age   = r_best_age;
        n_best_key   = r_best_key;
        n_status     = r_status;
        n_victim     = r_victim;
        n_out_count  = r_out_count;
        w_mem_we     = 1'b0;

        case (r_state)
            lrt_pkg::S_IDLE: begin
                // Latch the request and arm the scan.
                if (i_req.valid) begin
                    n_op         = lrt_pkg::t_opcode'(i_req.opcode);
                    n_key        = i_req.key;
                    n_cnt        = '0;
                    n_rd_valid   = 1'b0;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                    n_best_found = 1'b0;
                end
            end
            lrt_pkg::S_SCAN: begin
                // Issue the next read, then compare the slot read last cycle.
                n_cnt      = r_cnt + 1'b1;
                n_rd_valid = (r_cnt < lrt_pkg::COUNT_W'(CAP));
                n_rd_idx   = r_cnt[lrt_pkg::SLOT_W-1:0];
                if (r_rd_valid) begin
                    if (w_cur_valid && (r_rd_data == r_key) && !r_hit) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_rd_idx;
                        n_hit_age = w_cur_age;
                    end
                    if (!w_cur_valid && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_rd_idx;
                    end
                    if (w_cur_valid && (!r_best_found || (w_cur_age > r_best_age))) begin
                        n_best_found = 1'b1;
                        n_best_idx   = r_rd_idx;
                        n_best_age   = w_cur_age;
                        n_best_key   = r_rd_data;
                    end
                end
            end
            lrt_pkg::S_UPDATE: begin
                n_status = lrt_pkg::STAT_MISS;
                n_victim = '0;
                case (r_op)
                    lrt_pkg::OP_INSERT: begin
                        if (r_hit) begin
                            // Refresh: younger entries age by one.
                            for (int i = 0; i < CAP; i++) begin
                                if (r_valid[i] && (r_age[i] < r_hit_age)) begin
                                    n_age[i] = r_age[i] + 1'b1;
                                end
                            end
                            n_age[r_hit_idx] = '0;
                            n_status         = lrt_pkg::STAT_OK;
                        end else if (r_count >= lrt_pkg::COUNT_W'(CAP) || !r_free_found) begin
                            n_status = lrt_pkg::STAT_FULL;
                        end else begin
                            // New key: all entries age, key takes the free slot.
                            for (int i = 0; i < CAP; i++) begin
                                if (r_valid[i]) n_age[i] = r_age[i] + 1'b1;
                            end
                            n_valid[r_free_idx] = 1'b1;
                            n_age[r_free_idx]   = '0;
                            n_count             = r_count + 1'b1;
                            w_mem_we            = 1'b1;
                            n_status            = lrt_pkg::STAT_OK;
                        end
                    end
                    lrt_pkg::OP_EVICT: begin
                        if (r_best_found) begin
                            n_victim            = r_best_key;
                            n_valid[r_best_idx] = 1'b0;
                            n_age[r_best_idx]   = '0;
                            if (r_count != '0) n_count = r_count - 1'b1;
                            n_status            = lrt_pkg::STAT_OK;
                        end
                    end
                    lrt_pkg::OP_ERASE: begin
                        if (r_hit) begin
                            // Older entries move up by one.
                            for (int i = 0; i < CAP; i++) begin
                                if (r_valid[i] && (r_age[i] > r_hit_age)) begin
                                    n_age[i] = r_age[i] - 1'b1;
                                end
                            end
                            n_valid[r_hit_idx] = 1'b0;
                            n_age[r_hit_idx]   = '0;
                            if (r_count != '0) n_count = r_count - 1'b1;
                            n_status           = lrt_pkg::STAT_OK;
                        end
                    end
                    default: begin
                        n_status = lrt_pkg::STAT_MISS;
                    end
                endcase
                n_out_count = n_count;
            end
            lrt_pkg::S_RESP: begin
                n_rd_valid = 1'b0;
            end
            default: begin
                n_rd_valid = 1'b0;
            end
        endcase
    end

    // Key store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_key_mem[r_free_idx] <= r_key;
        end
        r_rd_data <= r_key_mem[r_cnt[lrt_pkg::SLOT_W-1:0]];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lrt_pkg::S_IDLE;
            r_count    <= '0;
            r_rd_valid <= 1'b0;
            for (int i = 0; i < CAP; i++) begin
                r_valid[i] <= 1'b0;
                r_age[i]   <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_rd_valid <= n_rd_valid;
            r_valid    <= n_valid;
            r_age      <= n_age;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_rd_idx     <= n_rd_idx;
        r_cnt        <= n_cnt;
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_hit_age    <= n_hit_age;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_best_found <= n_best_found;
        r_best_idx   <= n_best_idx;
        r_best_age   <= n_best_age;
        r_best_key   <= n_best_key;
        r_status     <= n_status;
        r_victim     <= n_victim;
        r_out_count  <= n_out_count;
    end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the LRU replacement table core
// Drives insert, evict, erase and unused-opcode beats through the request
// channel, predicts every response with a cycle-free software copy of the
// recency table, and compares each response beat field by field in order.
// ----------------------------------------------------------------------------

module tb;

    localparam int OP_W     = lrt_pkg::OP_W;
    localparam int KEY_W    = lrt_pkg::KEY_W;
    localparam int STAT_W   = lrt_pkg::STAT_W;
    localparam int COUNT_W  = lrt_pkg::COUNT_W;
    localparam int CAPACITY = lrt_pkg::CAPACITY;

    // The request field allows a fourth opcode that the block must treat as a no-op.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int ROWS       = 25;
    localparam int PHASE_BEATS = 231;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int POOL_SIZE  = 24;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [KEY_W-1:0]   victim;
        logic [COUNT_W-1:0] count;
    } t_lru_result;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [KEY_W-1:0]   key;
        bit                 typed;
        t_lru_result        result;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    lrt_req_if req_ch ();
    lrt_rsp_if rsp_ch ();

    lru_replacer_table_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the recency table.
    logic [KEY_W-1:0]   tbl_key   [CAPACITY];
    bit                 tbl_valid [CAPACITY];
    int unsigned        tbl_rank  [CAPACITY];
    int unsigned        tbl_held;

    t_lru_result        lru_pending [$];
    logic [KEY_W-1:0]   key_pool [POOL_SIZE];
    int                 fail_count;
    int                 rsp_seen;
    int                 idle_pct;
    int                 stall_pct;
    logic               hold_start;
    logic               rsp_hold;

    // Directed beats; typed results are the ones that follow from reset at a glance.
    t_dir_row dir_rows [ROWS] = '{
        '{lrt_pkg::OP_EVICT,  32'h0000_0000, 1'b1, '{lrt_pkg::STAT_MISS, 32'h0, 5'd0}},
        '{lrt_pkg::OP_ERASE,  32'h1234_5678, 1'b1, '{lrt_pkg::STAT_MISS, 32'h0, 5'd0}},
        '{OP_UNUSED,          32'hFFFF_FFFF, 1'b1, '{lrt_pkg::STAT_MISS, 32'h0, 5'd0}},
        '{lrt_pkg::OP_INSERT, 32'h0000_0000, 1'b1, '{lrt_pkg::STAT_OK,   32'h0, 5'd1}},
        '{lrt_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{lrt_pkg::STAT_OK,   32'h0, 5'd2}},
        '{lrt_pkg::OP_INSERT, 32'h0000_0001, 1'b0, '{lrt_pkg::STAT_OK,   32'h0, 5'd0}},
        '{lrt_pkg::OP_INSERT, 32'h8000_0000, 1'b0, '{lrt_pkg::STAT_OK,   32'h0, 5'd0}},
        '{lrt_pkg::OP_INSERT, 32'h5555_5555, 1'b0, '{lrt_pkg::STAT_OK,   32'h0, 5'd0}},
        '{lrt_pkg::OP_INSERT, 32'hAAAA_AAAA, 1'b0, '{lrt_pkg::STAT_OK,   32'h0, 5'd0}},
        '{lrt_pkg::OP_INSERT, 32'h0000_FFFF, 1'b0, '{lrt_pkg::STAT_OK,   32'h0, 5'd0}},
        '{lrt_pkg::OP_INSERT, 32'hFFFF_0000, 1'b0, '{lrt_pkg::STAT_OK,   32'h0, 5'd0}},
        '{lrt_pkg::OP_INSERT, 32'h0F0F_0F0F, 1'b0, '{lrt_pkg::STAT_OK,   32'h0, 5'd0}},
        '{lrt_pkg::OP_INSERT, 32'hF0F0_F0F0, 1'b0, '{lrt_pkg::STAT_OK,   32'h0, 5'd0}},
        '{lrt_pkg::OP_INSERT, 32'h1357_9BDF, 1'b0, '{lrt_pkg::STAT_OK,   32'h0, 5'd0}},
        '{lrt_pkg::OP_INSERT, 32'h2468_ACE0, 1'b0, '{lrt_pkg::STAT_OK,   32'h0, 5'd0}},
        '{lrt_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b0, '{lrt_pkg::STAT_OK,   32'h0, 5'd0}},
        '{lrt_pkg::OP_INSERT, 32'hFFFF_FFFE, 1'b0, '{lrt_pkg::STAT_OK,   32'h0, 5'd0}},
        '{lrt_pkg::OP_INSERT, 32'h0000_0002, 1'b0, '{lrt_pkg::STAT_OK,   32'h0, 5'd0}},
        '{lrt_pkg::OP_INSERT, 32'h4000_0000, 1'b0, '{lrt_pkg::STAT_OK,   32'h0, 5'd0}},
        '{lrt_pkg::OP_INSERT, 32'hDEAD_BEEF, 1'b1, '{lrt_pkg::STAT_FULL, 32'h0, 5'd16}},
        '{lrt_pkg::OP_INSERT, 32'h0000_0000, 1'b1, '{lrt_pkg::STAT_OK,   32'h0, 5'd16}},
        '{lrt_pkg::OP_EVICT,  32'h0000_0000, 1'b1, '{lrt_pkg::STAT_OK, 32'hFFFF_FFFF, 5'd15}},
        '{lrt_pkg::OP_ERASE,  32'hDEAD_BEEF, 1'b1, '{lrt_pkg::STAT_MISS, 32'h0, 5'd15}},
        '{lrt_pkg::OP_ERASE,  32'h0000_0000, 1'b1, '{lrt_pkg::STAT_OK,   32'h0, 5'd14}},
        '{OP_UNUSED,          32'h0000_0000, 1'b1, '{lrt_pkg::STAT_MISS, 32'h0, 5'd14}}
    };

    // Clock with a 20 ns period.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Applies one operation to the shadow table and returns the response it must cause.
    function automatic t_lru_result lru_apply(logic [OP_W-1:0] op, logic [KEY_W-1:0] k);
        t_lru_result r;
        int          hit;
        int          pick;
        int unsigned rk;
        r.status = lrt_pkg::STAT_MISS;
        r.victim = '0;
        hit      = -1;
        pick     = -1;
        for (int i = 0; i < CAPACITY; i++) begin
            if (hit < 0 && tbl_valid[i] && tbl_key[i] == k) hit = i;
        end
        case (op)
            lrt_pkg::OP_INSERT: begin
                if (hit >= 0) begin
                    // A refresh ages only the keys that were more recent than it.
                    rk = tbl_rank[hit];
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (tbl_valid[i] && tbl_rank[i] < rk) tbl_rank[i]++;
                    end
                    tbl_rank[hit] = 0;
                    r.status = lrt_pkg::STAT_OK;
                end else if (tbl_held >= CAPACITY) begin
                    r.status = lrt_pkg::STAT_FULL;
                end else begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (tbl_valid[i]) tbl_rank[i]++;
                        else if (pick < 0) pick = i;
                    end
                    tbl_valid[pick] = 1'b1;
                    tbl_key[pick]   = k;
                    tbl_rank[pick]  = 0;
                    tbl_held++;
                    r.status = lrt_pkg::STAT_OK;
                end
            end
            lrt_pkg::OP_EVICT: begin
                // The oldest key wins; ties would go to the lowest slot.
                for (int i = 0; i < CAPACITY; i++) begin
                    if (tbl_valid[i] && (pick < 0 || tbl_rank[i] > tbl_rank[pick])) pick = i;
                end
                if (pick >= 0) begin
                    r.victim         = tbl_key[pick];
                    tbl_valid[pick]  = 1'b0;
                    tbl_rank[pick]   = 0;
                    tbl_held--;
                    r.status = lrt_pkg::STAT_OK;
                end
            end
            lrt_pkg::OP_ERASE: begin
                if (hit >= 0) begin
                    rk = tbl_rank[hit];
                    tbl_valid[hit] = 1'b0;
                    tbl_rank[hit]  = 0;
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (tbl_valid[i] && tbl_rank[i] > rk) tbl_rank[i]--;
                    end
                    tbl_held--;
                    r.status = lrt_pkg::STAT_OK;
                end
            end
            default: r.status = lrt_pkg::STAT_MISS;
        endcase
        r.count = tbl_held[COUNT_W-1:0];
        return r;
    endfunction

    // Offers one request beat, with random idle cycles ahead of it, and records
    // the expected response once the beat has been taken.
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                             input bit typed, input t_lru_result typed_result);
        t_lru_result predicted;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= op;
        req_ch.key    <= k;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predicted = lru_apply(op, k);
        lru_pending.push_back(typed ? typed_result : predicted);
    endtask

    // Picks a key: mostly from a small pool so that hits are common, sometimes a
    // key that is held right now, and sometimes a fresh random value.
    function automatic logic [KEY_W-1:0] pick_key(bit want_held);
        int slot;
        slot = $urandom_range(CAPACITY - 1);
        if (want_held && tbl_valid[slot]) return tbl_key[slot];
        if ($urandom_range(3) == 0) return $urandom;
        return key_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    // One random beat; the mix swings between filling and draining the table.
    task automatic send_random(input int n);
        int          roll;
        logic [OP_W-1:0] op;
        bit          filling;
        t_lru_result none;
        none    = '0;
        filling = ((n / 40) % 2) == 0;
        roll    = $urandom_range(99);
        if (roll < 5)                     op = OP_UNUSED;
        else if (roll < (filling ? 75 : 30)) op = lrt_pkg::OP_INSERT;
        else if (roll < (filling ? 85 : 65)) op = lrt_pkg::OP_EVICT;
        else                              op = lrt_pkg::OP_ERASE;
        send_beat(op, pick_key(op == lrt_pkg::OP_ERASE ? ($urandom_range(9) < 7)
                                                       : ($urandom_range(9) < 3)),
                  1'b0, none);
    endtask

    // Receiver: random stalls, plus one long hold-off driven from its own process.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= !rsp_hold && (stall_pct == 0 || $urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        rsp_hold = 1'b0;
        wait (hold_start === 1'b1);
        @(posedge i_clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rsp_hold <= 1'b0;
    end

    // Response checker: every beat must match the oldest pending expectation.
    always @(posedge i_clk) begin
        t_lru_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen++;
            if (lru_pending.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("ERROR: response %0d arrived with nothing pending", rsp_seen);
            end else begin
                want = lru_pending.pop_front();
                if (rsp_ch.status !== want.status || rsp_ch.victim_key !== want.victim ||
                    rsp_ch.entry_count !== want.count) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: beat %0d want %0d/%h/%0d got %0d/%h/%0d",
                                 rsp_seen, want.status, want.victim, want.count,
                                 rsp_ch.status, rsp_ch.victim_key, rsp_ch.entry_count);
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        i_rst_n       = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.opcode = lrt_pkg::OP_INSERT;
        req_ch.key    = '0;
        hold_start    = 1'b0;
        fail_count    = 0;
        rsp_seen      = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        for (int i = 0; i < CAPACITY; i++) begin
            tbl_key[i]   = '0;
            tbl_valid[i] = 1'b0;
            tbl_rank[i]  = 0;
        end
        tbl_held = 0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats.
        foreach (dir_rows[i]) begin
            send_beat(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].result);
        end
        req_ch.valid <= 1'b0;
        wait (lru_pending.size() == 0);
        @(posedge i_clk);

        // Random phases: no idling, idle sender, stalling receiver, both.
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 58 : 23) : 0;
            stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 58 : 23) : 0;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (phase == 0 && n == 20) hold_start <= 1'b1;
                send_random(n);
            end
            // The sender rests until every pending response has come back.
            req_ch.valid <= 1'b0;
            wait (lru_pending.size() == 0);
            @(posedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && lru_pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
design/lrt_pkg.sv
design/lrt_if.sv
design/lru_replacer_table_core.sv
dv/tb.sv
